### rtl/core/bssc_pkg.sv
package bssc_pkg;

  localparam int unsigned TARGET_W        = 10;
  localparam int unsigned COUNT_W         = 19;
  localparam int unsigned MAX_LEN_DEFAULT = 1023;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [COUNT_W-1:0] running_count;
    logic               length_overflow;
  } result_t;

endpackage

### rtl/core/bssc_ram.sv
module bssc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/binary_subarray_sum_counter.sv
// Channel   Direction  Handshake                      Payload
// cfg       in         cfg_valid_i / cfg_ready_o      cfg_target_sum_i
// in        in         in_valid_i / in_ready_o        element_bit_i, start_of_array_i
// out       out        out_valid_o / out_ready_i      running_count_o, length_overflow_o
//
// One element is taken per cycle while in_ready_o is high; its result passes stage s1 and then enters the result queue.
// The histogram lives in a RAM holding the entries below the current prefix; the top
// entry and the prefix are kept in registers, so no clearing pass is needed at reset
// or at an array start. A four-entry result queue lets input continue while the output
// stalls; input is held off while the queue plus the result in flight hold three.
module binary_subarray_sum_counter #(
  parameter int unsigned MAX_LEN = bssc_pkg::MAX_LEN_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bssc_pkg::TARGET_W-1:0]  cfg_target_sum_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           element_bit_i,
  input  logic                           start_of_array_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bssc_pkg::COUNT_W-1:0]   running_count_o,
  output logic                           length_overflow_o
);

  import bssc_pkg::*;

  localparam int unsigned PW  = $clog2(MAX_LEN + 1);
  localparam int unsigned HW  = $clog2(MAX_LEN + 2);
  localparam int unsigned AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW  = ((PW > TARGET_W) ? PW : TARGET_W) + 1;
  localparam int unsigned SW  = COUNT_W + 1;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_AW      = 2;
  localparam int unsigned FIFO_CW      = 3;
  localparam int unsigned ACCEPT_LIMIT = FIFO_DEPTH - 2;

  logic [TARGET_W-1:0] target_q;
  logic [PW-1:0]       prefix_q, prefix_d;
  logic [PW-1:0]       seen_q, seen_d;
  logic [HW-1:0]       top_q, top_d;
  logic [COUNT_W-1:0]  total_q, total_d;

  logic                s1_valid_q;
  logic                s1_mem_q;
  logic                s1_add_q;
  logic                s1_ovf_q;
  logic                s1_clr_q;
  logic [HW-1:0]       s1_val_q;

  result_t             fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]  cnt_q, cnt_d;

  logic                in_fire, out_fire;
  logic [PW-1:0]       p_eff, seen_eff, p_new;
  logic [HW-1:0]       top_eff, addend;
  logic [CW-1:0]       p_ext, old_ext, t_ext, idx_ext;
  logic                ovf, ge, hit_top, hit_new, do_add, sel_mem;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [HW-1:0]       ram_rdata;
  logic [HW-1:0]       s1_addend;
  logic [SW-1:0]       sum;
  logic [COUNT_W-1:0]  base;
  result_t             push_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (cnt_q + FIFO_CW'(s1_valid_q)) <= FIFO_CW'(ACCEPT_LIMIT);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = cnt_q != '0;
  assign out_fire    = out_valid_o & out_ready_i;

  always_comb begin
    p_eff    = start_of_array_i ? '0 : prefix_q;
    seen_eff = start_of_array_i ? '0 : seen_q;
    top_eff  = start_of_array_i ? HW'(1) : top_q;
    ovf      = seen_eff >= PW'(MAX_LEN);
    p_new    = p_eff + PW'(element_bit_i);
    p_ext    = CW'(p_new);
    old_ext  = CW'(p_eff);
    t_ext    = CW'(target_q);
    ge       = p_ext >= t_ext;
    idx_ext  = p_ext - t_ext;
    hit_top  = idx_ext == old_ext;
    hit_new  = idx_ext == p_ext;
    do_add   = ge & ~ovf;
    sel_mem  = do_add & ~hit_top & ~hit_new;
    addend   = hit_top ? top_eff : '0;
  end

  assign ram_we    = in_fire & ~ovf & element_bit_i;
  assign ram_waddr = AW'(p_eff);
  assign ram_re    = in_fire & sel_mem;
  assign ram_raddr = AW'(idx_ext);

  bssc_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_LEN)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (top_eff),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    prefix_d = prefix_q;
    seen_d   = seen_q;
    top_d    = top_q;
    if (in_fire && !ovf) begin
      seen_d = seen_eff + PW'(1);
      if (element_bit_i) begin
        prefix_d = p_new;
        top_d    = HW'(1);
      end else begin
        prefix_d = p_eff;
        top_d    = top_eff + HW'(1);
      end
    end
  end

  always_comb begin
    s1_addend = s1_mem_q ? ram_rdata : s1_val_q;
    base      = s1_clr_q ? '0 : total_q;
    sum       = SW'(base) + SW'(s1_addend);
    total_d   = base;
    if (s1_add_q) begin
      total_d = (sum > SW'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
    end
    push_data.running_count   = total_d;
    push_data.length_overflow = s1_ovf_q;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (s1_valid_q && !out_fire) begin
      cnt_d = cnt_q + FIFO_CW'(1);
    end else if (!s1_valid_q && out_fire) begin
      cnt_d = cnt_q - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      prefix_q   <= '0;
      seen_q     <= '0;
      top_q      <= HW'(1);
      total_q    <= '0;
      s1_valid_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        target_q <= cfg_target_sum_i;
      end
      prefix_q   <= prefix_d;
      seen_q     <= seen_d;
      top_q      <= top_d;
      s1_valid_q <= in_fire;
      if (s1_valid_q) begin
        total_q  <= total_d;
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mem_q <= sel_mem;
      s1_add_q <= do_add;
      s1_ovf_q <= ovf;
      s1_clr_q <= start_of_array_i;
      s1_val_q <= addend;
    end
    if (s1_valid_q) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

  assign running_count_o   = fifo_q[rd_ptr_q].running_count;
  assign length_overflow_o = fifo_q[rd_ptr_q].length_overflow;

  a_fifo_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q + FIFO_CW'(s1_valid_q)) <= FIFO_CW'(FIFO_DEPTH - 1))
    else $error("Result queue would overflow.");

  a_prefix_le_seen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_q <= seen_q)
    else $error("Prefix count exceeds the number of elements seen.");

  a_seen_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= PW'(MAX_LEN))
    else $error("Element count exceeds the maximum array length.");

  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_re && ram_we) |-> (ram_raddr != ram_waddr))
    else $error("Histogram read and write hit the same entry.");

  a_start_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && start_of_array_i && !element_bit_i) |=> (prefix_q == '0 && seen_q == PW'(1)))
    else $error("Array start did not restart the prefix state.");

endmodule

### bench/tb_binary_subarray_sum_counter.sv
module tb_binary_subarray_sum_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import bssc_pkg::*;

  localparam int unsigned HIST_DEPTH  = MAX_LEN_DEFAULT + 1;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [TARGET_W-1:0] cfg_target_sum_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                element_bit_i;
  logic                start_of_array_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [COUNT_W-1:0]  running_count_o;
  logic                length_overflow_o;

  binary_subarray_sum_counter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_target_sum_i  (cfg_target_sum_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .element_bit_i     (element_bit_i),
    .start_of_array_i  (start_of_array_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .running_count_o   (running_count_o),
    .length_overflow_o (length_overflow_o)
  );

  logic [TARGET_W-1:0] target_q;
  int unsigned         prefix_q;
  int unsigned         seen_q;
  int unsigned         matches_q;
  int unsigned         hist_q [HIST_DEPTH];
  result_t             count_expect_q [$];

  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_array_state();
    prefix_q  = 0;
    seen_q    = 0;
    matches_q = 0;
    foreach (hist_q[i]) hist_q[i] = 0;
    hist_q[0] = 1;
  endfunction

  function automatic result_t predict_count(input logic bit_v, input logic start_v);
    result_t         res;
    int unsigned     idx;
    longint unsigned sum;
    if (start_v) begin
      clear_array_state();
    end
    res.length_overflow = 1'b0;
    if (seen_q >= MAX_LEN_DEFAULT) begin
      res.length_overflow = 1'b1;
    end else begin
      seen_q++;
      prefix_q += bit_v;
      if (prefix_q >= target_q) begin
        idx = prefix_q - target_q;
        if (idx < HIST_DEPTH) begin
          sum = longint'(matches_q) + hist_q[idx];
          if (sum > COUNT_MAX) begin
            matches_q = COUNT_MAX;
          end else begin
            matches_q = int'(sum);
          end
        end
      end
      if (prefix_q < HIST_DEPTH) begin
        hist_q[prefix_q]++;
      end
    end
    res.running_count = matches_q[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic send_element(input logic bit_v, input logic start_v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    element_bit_i    <= bit_v;
    start_of_array_i <= start_v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    count_expect_q.push_back(predict_count(bit_v, start_v));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (count_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [TARGET_W-1:0] value);
    wait_drained();
    cfg_valid_i      <= 1'b1;
    cfg_target_sum_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    target_q = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_stream_without_start();
    send_element(1'b0, 1'b0);
    send_element(1'b0, 1'b0);
    send_element(1'b1, 1'b0);
    send_element(1'b0, 1'b0);
  endtask

  task automatic test_start_and_targets();
    write_target(TARGET_W'(1));
    send_element(1'b1, 1'b1);
    send_element(1'b0, 1'b0);
    send_element(1'b1, 1'b0);
    send_element(1'b1, 1'b0);
    send_element(1'b0, 1'b0);
    write_target(TARGET_W'(2));
    send_element(1'b1, 1'b1);
    send_element(1'b1, 1'b1);
    send_element(1'b1, 1'b0);
    send_element(1'b0, 1'b1);
  endtask

  task automatic test_target_above_prefix();
    write_target('1);
    send_element(1'b1, 1'b1);
    send_element(1'b1, 1'b0);
    send_element(1'b0, 1'b0);
  endtask

  // A full array of zeros against target zero reaches the largest count;
  // the elements after it overflow.
  task automatic test_length_overflow();
    write_target(TARGET_W'(0));
    for (int i = 0; i < MAX_LEN_DEFAULT + 5; i++) begin
      send_element((i < MAX_LEN_DEFAULT) ? 1'b0 : 1'($urandom_range(1)), i == 0);
    end
    send_element(1'b1, 1'b1);
  endtask

  task automatic test_output_backpressure();
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) begin
      send_element(1'($urandom_range(1)), i == 0);
    end
    wait_drained();
  endtask

  task automatic test_random_arrays(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned density;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        write_target(TARGET_W'(($urandom_range(9) == 0) ? $urandom_range(1023)
                                                        : $urandom_range(6)));
      end
      len     = ($urandom_range(15) == 0) ? $urandom_range(60, 30) : $urandom_range(20, 1);
      density = $urandom_range(100);
      for (int i = 0; i < len; i++) begin
        send_element($urandom_range(99) < density,
                     (i == 0 && $urandom_range(9) != 0) || $urandom_range(49) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    result_t exp_res;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (count_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result count=%0d overflow=%0b",
                                    running_count_o, length_overflow_o));
        end else begin
          exp_res = count_expect_q.pop_front();
          if (running_count_o !== exp_res.running_count) begin
            report_mismatch($sformatf("running_count got %0d expected %0d",
                                      running_count_o, exp_res.running_count));
          end
          if (length_overflow_o !== exp_res.length_overflow) begin
            report_mismatch($sformatf("length_overflow got %0b expected %0b",
                                      length_overflow_o, exp_res.length_overflow));
          end
        end
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_target_sum_i <= '0;
    in_valid_i       <= 1'b0;
    element_bit_i    <= 1'b0;
    start_of_array_i <= 1'b0;
    error_count   = 0;
    hold_left     = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    target_q      = '0;
    clear_array_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 27;
    recv_idle_pct = 74;
    test_stream_without_start();
    test_start_and_targets();
    test_target_above_prefix();
    test_length_overflow();

    send_idle_pct = 74;
    recv_idle_pct = 27;
    test_random_arrays(50);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_arrays(50);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
